[hw/rtl/block_weighted_color_distance_core_defines.svh]
// assertion macros shared by the checker of the weighted colour distance core
// no dependencies; clk and rst_n must be visible where the macros are used
`ifndef BLOCK_WEIGHTED_COLOR_DISTANCE_CORE_DEFINES_SVH
`define BLOCK_WEIGHTED_COLOR_DISTANCE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define BWCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define BWCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bwcd_pkg.sv]
// shared widths, depths and result word type of the weighted colour distance core
// no dependencies
package bwcd_pkg;

  localparam int CH_W      = 8;
  localparam int SQ_W      = 2 * CH_W;
  localparam int PAIR_W    = 29;
  localparam int SUM_W     = 33;
  localparam int PSUM_W    = 31;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  localparam logic [PAIR_W-1:0] PAIR_MAX = {PAIR_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  typedef struct packed {
    logic [PAIR_W-1:0] pair_distance;
    logic              block_done;
    logic [SUM_W-1:0]  block_sum;
  } out_word_t;

endpackage

[hw/rtl/bwcd_fifo.sv]
// small synchronous first-in first-out queue built from flip-flops
// no dependencies; used for the front-to-back queue and the result queue
module bwcd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign count    = count_r;
  assign pop_data = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[hw/rtl/bwcd_front.sv]
// front end: takes pixel pairs, clamps channels, forms differences and weights,
// and marks the pair that closes a block; depends on bwcd_pkg
module bwcd_front import bwcd_pkg::*; #(
  parameter int BLOCK_PIXELS = 16,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [CH_W-1:0]      in_first_red,
  input  logic [CH_W-1:0]      in_first_green,
  input  logic [CH_W-1:0]      in_first_blue,
  input  logic [CH_W-1:0]      in_second_red,
  input  logic [CH_W-1:0]      in_second_green,
  input  logic [CH_W-1:0]      in_second_blue,
  output logic                 mid_push,
  output logic [1+2*(CHANNEL_BITS+3)+3*CH_W-1:0] mid_data,
  input  logic                 mid_full
);

  localparam int CH_MAX  = (1 << CHANNEL_BITS) - 1;
  localparam int CLAMP   = (CH_MAX > 255) ? 255 : CH_MAX;
  localparam int WGT_W   = CHANNEL_BITS + 3;
  localparam int CNT_W   = (BLOCK_PIXELS > 1) ? $clog2(BLOCK_PIXELS) : 1;
  localparam logic [CH_W-1:0]  CLAMP_V = CH_W'(CLAMP);
  localparam logic [WGT_W-1:0] FOUR_M  = WGT_W'(4 * CH_MAX);
  localparam logic [WGT_W-1:0] SIX_M   = WGT_W'(6 * CH_MAX);
  localparam logic [CNT_W-1:0] LAST_IX = CNT_W'(BLOCK_PIXELS - 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CH_W-1:0]  ra, ga, ba, rb, gb, bb;
  logic [CH_W-1:0]  dr, dg, db;
  logic [CH_W:0]    rsum;
  logic [WGT_W-1:0] wr, wb;
  logic             last;

  function automatic logic [CH_W-1:0] clamp_ch(input logic [CH_W-1:0] v);
    clamp_ch = (v > CLAMP_V) ? CLAMP_V : v;
  endfunction

  function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] b);
    abs_diff = (a > b) ? a - b : b - a;
  endfunction

  assign ra = clamp_ch(in_first_red);
  assign ga = clamp_ch(in_first_green);
  assign ba = clamp_ch(in_first_blue);
  assign rb = clamp_ch(in_second_red);
  assign gb = clamp_ch(in_second_green);
  assign bb = clamp_ch(in_second_blue);

  assign dr   = abs_diff(ra, rb);
  assign dg   = abs_diff(ga, gb);
  assign db   = abs_diff(ba, bb);
  assign rsum = {1'b0, ra} + {1'b0, rb};
  assign wr   = FOUR_M + WGT_W'(rsum);
  assign wb   = SIX_M - WGT_W'(rsum);
  assign last = (cnt_r == LAST_IX);

  assign in_full  = mid_full;
  assign mid_push = in_push && !mid_full;
  assign mid_data = {last, wr, wb, dr, dg, db};

  always_comb begin
    cnt_nxt = cnt_r;
    if (mid_push) begin
      cnt_nxt = last ? '0 : cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/bwcd_back.sv]
// back end: squares, weights, saturates and accumulates each queued pair
// depends on bwcd_pkg; pops the front queue only when the result queue has room
module bwcd_back import bwcd_pkg::*; #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 mid_empty,
  input  logic [1+2*(CHANNEL_BITS+3)+3*CH_W-1:0] mid_data,
  output logic                 mid_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                 res_push,
  output out_word_t            res_data
);

  localparam int CH_MAX = (1 << CHANNEL_BITS) - 1;
  localparam int WGT_W  = CHANNEL_BITS + 3;
  localparam int PROD_W = WGT_W + SQ_W;
  localparam int OCNT_W = $clog2(OUT_DEPTH + 1);
  localparam logic [WGT_W-1:0]  EIGHT_M = WGT_W'(8 * CH_MAX);
  localparam logic [OCNT_W-1:0] ROOM    = OCNT_W'(OUT_DEPTH);

  logic             m_last;
  logic [WGT_W-1:0] m_wr, m_wb;
  logic [CH_W-1:0]  m_dr, m_dg, m_db;

  // stage 1: squares
  logic              s1_v_r;
  logic              s1_last_r;
  logic [WGT_W-1:0]  s1_wr_r, s1_wb_r;
  logic [SQ_W-1:0]   s1_sr_r, s1_sg_r, s1_sb_r;
  // stage 2: weighted terms
  logic              s2_v_r;
  logic              s2_last_r;
  logic [PROD_W-1:0] s2_pr_r, s2_pg_r, s2_pb_r;
  // stage 3: saturated pair value
  logic              s3_v_r;
  logic              s3_last_r;
  logic [PAIR_W-1:0] s3_pair_r;

  logic [PSUM_W-1:0] psum;
  logic [PAIR_W-1:0] pair_sat;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SUM_W:0]    acc;
  logic [SUM_W-1:0]  acc_sat;
  logic [OCNT_W-1:0] inflight;

  assign {m_last, m_wr, m_wb, m_dr, m_dg, m_db} = mid_data;

  assign inflight = OCNT_W'(s1_v_r) + OCNT_W'(s2_v_r) + OCNT_W'(s3_v_r);
  assign mid_pop  = !mid_empty && ((out_count + inflight) < ROOM);

  assign psum     = PSUM_W'(s2_pr_r) + PSUM_W'(s2_pg_r) + PSUM_W'(s2_pb_r);
  assign pair_sat = (psum > PSUM_W'(PAIR_MAX)) ? PAIR_MAX : psum[PAIR_W-1:0];

  assign acc     = {1'b0, sum_r} + (SUM_W+1)'(s3_pair_r);
  assign acc_sat = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];

  always_comb begin
    sum_nxt = sum_r;
    if (s3_v_r) begin
      sum_nxt = s3_last_r ? '0 : acc_sat;
    end
  end

  assign res_push               = s3_v_r;
  assign res_data.pair_distance = s3_pair_r;
  assign res_data.block_done    = s3_last_r;
  assign res_data.block_sum     = s3_last_r ? acc_sat : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      sum_r  <= '0;
    end else begin
      s1_v_r <= mid_pop;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_last_r <= m_last;
    s1_wr_r   <= m_wr;
    s1_wb_r   <= m_wb;
    s1_sr_r   <= SQ_W'(m_dr) * SQ_W'(m_dr);
    s1_sg_r   <= SQ_W'(m_dg) * SQ_W'(m_dg);
    s1_sb_r   <= SQ_W'(m_db) * SQ_W'(m_db);

    s2_last_r <= s1_last_r;
    s2_pr_r   <= PROD_W'(s1_wr_r) * PROD_W'(s1_sr_r);
    s2_pg_r   <= PROD_W'(EIGHT_M) * PROD_W'(s1_sg_r);
    s2_pb_r   <= PROD_W'(s1_wb_r) * PROD_W'(s1_sb_r);

    s3_last_r <= s2_last_r;
    s3_pair_r <= pair_sat;
  end

endmodule

[hw/rtl/block_weighted_color_distance_core.sv]
// Red-weighted squared colour distance over blocks of pixel pairs.
// Input queue: in_push / in_full, one pixel pair (two RGB colours) per word,
// taken at an edge with in_push high and in_full low.
// Result queue: out_empty / out_pop, one result word per pair, in order:
// out_pair_distance, and on the pair that closes a block of BLOCK_PIXELS
// pairs out_block_done with out_block_sum (zero otherwise).
// A pair taken passes the front queue, the squares, weighted-term and saturated
// pair stages of the back end and the result queue before it shows on the ports.
// Throughput: one pair per cycle while the receiver keeps popping; the multiply pipeline in the back end
// takes one word per cycle and the block sum adds once per cycle.
// The back end pops the front queue only while the result queue has room
// for every word in flight, so when the receiver stops popping the result
// queue fills, then the front queue, then in_full rises; nothing is lost.
// Reset (rst_n low at an edge) empties both queues, clears the pair count
// and the block sum.
// depends on bwcd_pkg, bwcd_fifo, bwcd_front and bwcd_back
module block_weighted_color_distance_core import bwcd_pkg::*; #(
  parameter int BLOCK_PIXELS = 16,
  parameter int CHANNEL_BITS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [CH_W-1:0]   in_first_red,
  input  logic [CH_W-1:0]   in_first_green,
  input  logic [CH_W-1:0]   in_first_blue,
  input  logic [CH_W-1:0]   in_second_red,
  input  logic [CH_W-1:0]   in_second_green,
  input  logic [CH_W-1:0]   in_second_blue,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [PAIR_W-1:0] out_pair_distance,
  output logic              out_block_done,
  output logic [SUM_W-1:0]  out_block_sum
);

  localparam int MID_W = 1 + 2 * (CHANNEL_BITS + 3) + 3 * CH_W;

  logic             mid_push, mid_full, mid_pop, mid_empty;
  logic [MID_W-1:0] mid_wdata, mid_rdata;
  logic             res_push;
  out_word_t        res_data, res_head;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

  bwcd_front #(
    .BLOCK_PIXELS (BLOCK_PIXELS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_first_red    (in_first_red),
    .in_first_green  (in_first_green),
    .in_first_blue   (in_first_blue),
    .in_second_red   (in_second_red),
    .in_second_green (in_second_green),
    .in_second_blue  (in_second_blue),
    .mid_push        (mid_push),
    .mid_data        (mid_wdata),
    .mid_full        (mid_full)
  );

  bwcd_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (mid_push),
    .push_data (mid_wdata),
    .full      (mid_full),
    .pop       (mid_pop),
    .pop_data  (mid_rdata),
    .empty     (mid_empty),
    .count     ()
  );

  bwcd_back #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_data  (mid_rdata),
    .mid_pop   (mid_pop),
    .out_count (out_count),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  bwcd_fifo #(
    .WIDTH ($bits(out_word_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .full      (),
    .pop       (out_pop),
    .pop_data  (res_head),
    .empty     (out_empty),
    .count     (out_count)
  );

  assign out_pair_distance = res_head.pair_distance;
  assign out_block_done    = res_head.block_done;
  assign out_block_sum     = res_head.block_sum;

endmodule

[hw/rtl/bwcd_checker.sv]
// port-level checks on the weighted colour distance core, bound to the top level
// depends on bwcd_pkg and block_weighted_color_distance_core_defines.svh
`include "block_weighted_color_distance_core_defines.svh"

module bwcd_checker import bwcd_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_push,
  input logic              in_full,
  input logic [CH_W-1:0]   in_first_red,
  input logic [CH_W-1:0]   in_first_green,
  input logic [CH_W-1:0]   in_first_blue,
  input logic [CH_W-1:0]   in_second_red,
  input logic [CH_W-1:0]   in_second_green,
  input logic [CH_W-1:0]   in_second_blue,
  input logic              out_empty,
  input logic              out_pop,
  input logic [PAIR_W-1:0] out_pair_distance,
  input logic              out_block_done,
  input logic [SUM_W-1:0]  out_block_sum
);

  // block sum includes the closing pair
  `BWCD_ASSERT_NOW(a_sum_covers_pair, !out_empty && out_block_done, SUM_W'(out_pair_distance) <= out_block_sum, "block sum below its closing pair distance")

  // no block sum on a word that does not close a block
  `BWCD_ASSERT_NOW(a_sum_zero_mid_block, !out_empty && !out_block_done, out_block_sum == '0, "block sum set on a word inside a block")

  // a waiting word holds until popped
  `BWCD_ASSERT_NEXT(a_head_holds, !out_empty && !out_pop, !out_empty && $stable(out_pair_distance) && $stable(out_block_done) && $stable(out_block_sum), "waiting result word changed before pop")

endmodule

bind block_weighted_color_distance_core bwcd_checker u_checker (.*);

[test/block_weighted_color_distance_core_checker.sv]
// checker for the weighted colour distance core: predicts each result word and compares it
// depends on bwcd_pkg; watches both queue channels of the core
module block_weighted_color_distance_core_checker import bwcd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic              in_full,
  input  logic [CH_W-1:0]   in_first_red,
  input  logic [CH_W-1:0]   in_first_green,
  input  logic [CH_W-1:0]   in_first_blue,
  input  logic [CH_W-1:0]   in_second_red,
  input  logic [CH_W-1:0]   in_second_green,
  input  logic [CH_W-1:0]   in_second_blue,
  input  logic              out_empty,
  input  logic              out_pop,
  input  logic [PAIR_W-1:0] out_pair_distance,
  input  logic              out_block_done,
  input  logic [SUM_W-1:0]  out_block_sum,
  output int unsigned       fault_count,
  output int unsigned       words_in_flight
);

  localparam int unsigned BLOCK_PIXELS = 16;
  localparam logic [63:0] CH_MAX = 64'd255;

  out_word_t        expected_words[$];
  int unsigned      block_fill = 0;
  logic [SUM_W-1:0] block_total = '0;
  int unsigned      faults = 0;

  assign fault_count = faults;

  initial words_in_flight = 0;

  function automatic logic [63:0] sq_gap(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b);
    logic [63:0] d;
    d = (a > b) ? 64'(a - b) : 64'(b - a);
    return d * d;
  endfunction

  // weighted distance of one pair, with the block sum carried across words
  function automatic out_word_t weigh_pair(
    input logic [CH_W-1:0] ra, input logic [CH_W-1:0] ga, input logic [CH_W-1:0] ba,
    input logic [CH_W-1:0] rb, input logic [CH_W-1:0] gb, input logic [CH_W-1:0] bb
  );
    logic [63:0] red_sum;
    logic [63:0] pair_val;
    logic [63:0] total;
    out_word_t   w;
    red_sum = 64'(ra) + 64'(rb);
    pair_val = (4 * CH_MAX + red_sum) * sq_gap(ra, rb)
             + 8 * CH_MAX * sq_gap(ga, gb)
             + (6 * CH_MAX - red_sum) * sq_gap(ba, bb);
    if (pair_val > 64'(PAIR_MAX)) pair_val = 64'(PAIR_MAX);
    total = 64'(block_total) + pair_val;
    if (total > 64'(SUM_MAX)) total = 64'(SUM_MAX);
    block_fill++;
    w.pair_distance = pair_val[PAIR_W-1:0];
    if (block_fill >= BLOCK_PIXELS) begin
      w.block_done = 1'b1;
      w.block_sum  = total[SUM_W-1:0];
      block_total  = '0;
      block_fill   = 0;
    end else begin
      w.block_done = 1'b0;
      w.block_sum  = '0;
      block_total  = total[SUM_W-1:0];
    end
    return w;
  endfunction

  always @(posedge clk) begin : watch
    out_word_t want;
    if (!rst_n) begin
      expected_words.delete();
      block_fill      = 0;
      block_total     = '0;
      words_in_flight <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_words.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("unexpected result word: dist %0d done %0b sum %0d",
                     out_pair_distance, out_block_done, out_block_sum);
        end else begin
          want = expected_words.pop_front();
          if (out_pair_distance !== want.pair_distance || out_block_done !== want.block_done ||
              out_block_sum !== want.block_sum) begin
            faults++;
            if (faults <= 10)
              $display("mismatch: expected dist %0d done %0b sum %0d, got dist %0d done %0b sum %0d",
                       want.pair_distance, want.block_done, want.block_sum,
                       out_pair_distance, out_block_done, out_block_sum);
          end
        end
      end
      if (in_push && !in_full)
        expected_words.push_back(weigh_pair(in_first_red, in_first_green, in_first_blue,
                                            in_second_red, in_second_green, in_second_blue));
      words_in_flight <= expected_words.size();
    end
  end

endmodule

[test/block_weighted_color_distance_core_tb.sv]
// testbench top for the weighted colour distance core: clock, reset, pixel pair stimulus
// and result popping; depends on bwcd_pkg, the core and its checker
module block_weighted_color_distance_core_tb;
  import bwcd_pkg::*;

  localparam int unsigned RANDOM_PAIRS = 1000;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_push = 1'b0;
  logic              in_full;
  logic [CH_W-1:0]   in_first_red = '0;
  logic [CH_W-1:0]   in_first_green = '0;
  logic [CH_W-1:0]   in_first_blue = '0;
  logic [CH_W-1:0]   in_second_red = '0;
  logic [CH_W-1:0]   in_second_green = '0;
  logic [CH_W-1:0]   in_second_blue = '0;
  logic              out_empty;
  logic              out_pop = 1'b0;
  logic [PAIR_W-1:0] out_pair_distance;
  logic              out_block_done;
  logic [SUM_W-1:0]  out_block_sum;

  int unsigned fault_count;
  int unsigned words_in_flight;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  int unsigned pop_mode = 0;
  int unsigned pop_window = 0;

  always #4 clk = ~clk;

  block_weighted_color_distance_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_first_red     (in_first_red),
    .in_first_green   (in_first_green),
    .in_first_blue    (in_first_blue),
    .in_second_red    (in_second_red),
    .in_second_green  (in_second_green),
    .in_second_blue   (in_second_blue),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pair_distance(out_pair_distance),
    .out_block_done   (out_block_done),
    .out_block_sum    (out_block_sum)
  );

  block_weighted_color_distance_core_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_first_red     (in_first_red),
    .in_first_green   (in_first_green),
    .in_first_blue    (in_first_blue),
    .in_second_red    (in_second_red),
    .in_second_green  (in_second_green),
    .in_second_blue   (in_second_blue),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pair_distance(out_pair_distance),
    .out_block_done   (out_block_done),
    .out_block_sum    (out_block_sum),
    .fault_count      (fault_count),
    .words_in_flight  (words_in_flight)
  );

  // receiver: windows of full rate, coin toss, sparse pops and full stop
  always @(posedge clk) begin
    if (pop_window == 0) begin
      pop_mode   <= $urandom_range(0, 3);
      pop_window <= $urandom_range(10, 60);
    end else begin
      pop_window <= pop_window - 1;
    end
    case (pop_mode)
      0: out_pop <= 1'b1;
      1: out_pop <= 1'($urandom_range(0, 1));
      2: out_pop <= ($urandom_range(0, 7) == 0);
      default: out_pop <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_pair(
    input logic [CH_W-1:0] ra, input logic [CH_W-1:0] ga, input logic [CH_W-1:0] ba,
    input logic [CH_W-1:0] rb, input logic [CH_W-1:0] gb, input logic [CH_W-1:0] bb
  );
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_push         <= 1'b1;
    in_first_red    <= ra;
    in_first_green  <= ga;
    in_first_blue   <= ba;
    in_second_red   <= rb;
    in_second_green <= gb;
    in_second_blue  <= bb;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // hold off until every word sent has come back
  task automatic drain();
    in_push <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
  endtask

  initial begin
    logic [CH_W-1:0] c [6];
    int unsigned     k;
    int unsigned     i;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // a whole block of the largest pair, both ways round
    for (k = 0; k < 16; k++) begin
      if (k % 2) send_pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
      else       send_pair(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
    end
    send_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pair(8'd37, 8'd200, 8'd99, 8'd37, 8'd200, 8'd99);
    send_pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_pair(8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pair(8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pair(8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0);
    send_pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    send_pair(8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0);
    send_pair(8'd170, 8'd85, 8'd170, 8'd85, 8'd170, 8'd85);
    drain();

    for (k = 0; k < RANDOM_PAIRS; k++) begin
      if (k == RANDOM_PAIRS / 2) drain();
      for (i = 0; i < 6; i++) c[i] = 8'($urandom);
      case ($urandom_range(0, 9))
        0: for (i = 0; i < 3; i++) c[i+3] = c[i];
        1: for (i = 0; i < 6; i++) c[i] = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
        2: for (i = 0; i < 3; i++) c[i+3] = c[i] + 8'($urandom_range(0, 6)) - 8'd3;
        default: ;
      endcase
      send_pair(c[0], c[1], c[2], c[3], c[4], c[5]);
    end
    drain();
    repeat (10) @(posedge clk);

    if (fault_count == 0 && words_in_flight == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
